// ===== hw/rtl/utf8_indexed_char_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// UTF-8 indexed character decoder assertion macros
// Assertion macros shared by the decoder RTL; they compile to nothing when
// ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef UTF8_INDEXED_CHAR_DECODER_ASSERT_SVH
`define UTF8_INDEXED_CHAR_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define UTF8IC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define UTF8IC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define UTF8IC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define UTF8IC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/utf8ic_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 indexed character decoder package
// Item types, field widths and lead-byte constants of the decoder.
// ----------------------------------------------------------------------------
package utf8ic_pkg;

    localparam int BYTE_W          = 8;
    localparam int CP_W            = 21;
    localparam int INDEX_W         = 16;
    localparam int COUNT_OUT_W     = 16;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int LEFT_W          = 2;

    // Lead-byte class boundaries.
    localparam logic [BYTE_W-1:0] ASCII_LIMIT   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_FIRST   = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_FIRST   = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_FIRST   = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_LAST    = 8'hF7;

    // Payload masks.
    localparam logic [BYTE_W-1:0] CONT_MASK     = 8'h3F;
    localparam logic [BYTE_W-1:0] LEAD2_MASK    = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK    = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK    = 8'h07;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              final_byte;
    } t_in_item;

    typedef struct packed {
        logic [CP_W-1:0]        code_point;
        logic                   target_found;
        logic [COUNT_OUT_W-1:0] char_count;
    } t_out_item;

endpackage

// ===== hw/rtl/utf8_indexed_char_decoder.sv =====
// ----------------------------------------------------------------------------
// UTF-8 indexed character decoder
// Walks a byte-serial UTF-8 string and returns the code point at a chosen
// character index together with the character count.
// ----------------------------------------------------------------------------
// The decoder takes one string byte per cycle while not stalled, with no gaps
// needed between strings, and gives exactly one result item when the byte
// marked final is taken, through the result register or, while that is
// held, the skid register. The byte step is a single pass of shallow logic
// from the decoder state registers into the result register. A two-entry
// output buffer (result register plus a skid register) lets input keep
// flowing while a result waits; input stalls only while both entries are
// full. The character index to look up is written through the configuration
// port, which is always ready and should be written only between strings.
module utf8_indexed_char_decoder
    import utf8ic_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // Configuration write channel: target character index.
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [INDEX_W-1:0]  i_cfg_data,

    // Byte input channel.
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_in_item,

    // Result output channel.
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_item
);

    `include "utf8_indexed_char_decoder_assert.svh"

    // Width used to compare the character position against the index and to
    // saturate the reported count.
    localparam int CMP_W = (COUNT_BITS > INDEX_W) ? COUNT_BITS : INDEX_W;
    localparam logic [CMP_W-1:0] COUNT_OUT_MAX = CMP_W'({COUNT_OUT_W{1'b1}});

    // Configuration register.
    logic [INDEX_W-1:0]     r_target_index;

    // Per-string decoder state.
    logic [LEFT_W-1:0]      r_bytes_left,     n_bytes_left;
    logic [CP_W-1:0]        r_accumulator,    n_accumulator;
    logic [COUNT_BITS-1:0]  r_char_counter,   n_char_counter;
    logic                   r_walk_stuck,     n_walk_stuck;
    logic                   r_capturing,      n_capturing;
    logic [CP_W-1:0]        r_captured_point, n_captured_point;
    logic                   r_captured_valid, n_captured_valid;

    // Output buffer.
    logic                   r_out_valid;
    t_out_item              r_out;
    logic                   r_skid_valid;
    t_out_item              r_skid;

    logic                   in_fire;
    logic                   out_fire;
    logic                   res_valid;
    t_out_item              res_item;

    logic [BYTE_W-1:0]      byte_in;
    logic                   lead_invalid;
    logic [BYTE_W-1:0]      lead_bits;
    logic [LEFT_W-1:0]      lead_left;
    logic [CMP_W-1:0]       pos_ext;
    logic [CMP_W-1:0]       target_ext;
    logic [CP_W-1:0]        acc_shifted;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_fire     = i_in_valid && !r_skid_valid;
    assign out_fire    = r_out_valid && !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign byte_in     = i_in_item.text_byte;
    assign pos_ext     = CMP_W'(r_char_counter);
    assign target_ext  = CMP_W'(r_target_index);
    assign acc_shifted = {r_accumulator[CP_W-7:0], byte_in[5:0] & CONT_MASK[5:0]};

    // Classify a lead byte: sequence length follows the counting rule, and
    // stray continuation bytes and bytes above the four-byte range are
    // invalid as leads even though they still count as characters.
    always_comb begin
        lead_invalid = (byte_in inside {[ASCII_LIMIT:LEAD2_FIRST - 8'd1]})
                    || (byte_in > LEAD4_LAST);
        if (byte_in < ASCII_LIMIT) begin
            lead_left = 2'd0;
            lead_bits = byte_in;
        end else if (byte_in < LEAD3_FIRST) begin
            lead_left = 2'd1;
            lead_bits = byte_in & LEAD2_MASK;
        end else if (byte_in < LEAD4_FIRST) begin
            lead_left = 2'd2;
            lead_bits = byte_in & LEAD3_MASK;
        end else begin
            lead_left = 2'd3;
            lead_bits = byte_in & LEAD4_MASK;
        end
    end

    // One byte step of the decoder, then the result of the string and the
    // per-string clear when the byte is the final one.
    always_comb begin
        n_bytes_left     = r_bytes_left;
        n_accumulator    = r_accumulator;
        n_char_counter   = r_char_counter;
        n_walk_stuck     = r_walk_stuck;
        n_capturing      = r_capturing;
        n_captured_point = r_captured_point;
        n_captured_valid = r_captured_valid;
        res_valid        = 1'b0;
        res_item         = '0;

        if (in_fire) begin
            if (r_bytes_left == '0) begin
                // A lead byte starts a new character at position r_char_counter.
                if (!r_walk_stuck && !r_captured_valid && pos_ext <= target_ext) begin
                    if (lead_invalid) begin
                        n_walk_stuck = 1'b1;
                    end else if (pos_ext == target_ext) begin
                        if (lead_left == '0) begin
                            n_captured_point = CP_W'(byte_in);
                            n_captured_valid = 1'b1;
                        end else begin
                            n_capturing   = 1'b1;
                            n_accumulator = CP_W'(lead_bits);
                        end
                    end
                end
                if (r_char_counter != {COUNT_BITS{1'b1}}) begin
                    n_char_counter = r_char_counter + COUNT_BITS'(1);
                end
                n_bytes_left = lead_left;
            end else begin
                // Continuation byte: taken as such whatever its value.
                n_bytes_left = r_bytes_left - LEFT_W'(1);
                if (r_capturing) begin
                    n_accumulator = acc_shifted;
                    if (r_bytes_left == LEFT_W'(1)) begin
                        n_captured_point = acc_shifted;
                        n_captured_valid = 1'b1;
                        n_capturing      = 1'b0;
                    end
                end
            end

            if (i_in_item.final_byte) begin
                res_valid               = 1'b1;
                res_item.code_point     = n_captured_valid ? n_captured_point : '0;
                res_item.target_found   = n_captured_valid;
                if (CMP_W'(n_char_counter) > COUNT_OUT_MAX) begin
                    res_item.char_count = {COUNT_OUT_W{1'b1}};
                end else begin
                    res_item.char_count = COUNT_OUT_W'(CMP_W'(n_char_counter));
                end
                // A sequence cut short simply ends here; nothing carries over.
                n_bytes_left     = '0;
                n_accumulator    = '0;
                n_char_counter   = '0;
                n_walk_stuck     = 1'b0;
                n_capturing      = 1'b0;
                n_captured_point = '0;
                n_captured_valid = 1'b0;
            end
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_index <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_target_index <= i_cfg_data;
        end
    end

    // Decoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left     <= '0;
            r_accumulator    <= '0;
            r_char_counter   <= '0;
            r_walk_stuck     <= 1'b0;
            r_capturing      <= 1'b0;
            r_captured_point <= '0;
            r_captured_valid <= 1'b0;
        end else begin
            r_bytes_left     <= n_bytes_left;
            r_accumulator    <= n_accumulator;
            r_char_counter   <= n_char_counter;
            r_walk_stuck     <= n_walk_stuck;
            r_capturing      <= n_capturing;
            r_captured_point <= n_captured_point;
            r_captured_valid <= n_captured_valid;
        end
    end

    // Output buffer. The skid register fills only when a new result arrives
    // while the result register is held by a stalled consumer; while it is
    // full the input stalls, so no result can be dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out <= res_item;
            end else begin
                r_skid <= res_item;
            end
        end
    end

    // The skid entry is only ever used behind a full result register.
    `UTF8IC_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    // A result without a found target carries a zero code point.
    `UTF8IC_ASSERT_IMP(a_zero_when_missing, i_clk, i_rst_n,
        r_out_valid && !r_out.target_found, r_out.code_point == '0)
    // Capture is in progress only while continuation bytes are still due.
    `UTF8IC_ASSERT_IMP(a_capture_needs_cont, i_clk, i_rst_n,
        r_capturing, r_bytes_left != '0 && !r_captured_valid)
    // A final byte always leaves the per-string state cleared.
    `UTF8IC_ASSERT_NEXT(a_clear_after_final, i_clk, i_rst_n,
        in_fire && i_in_item.final_byte,
        r_char_counter == '0 && r_bytes_left == '0 && !r_captured_valid)

endmodule
